// ===== rtl/mbrtu_pkg.sv =====
package mbrtu_pkg;

  localparam int MAX_FRAME_DEF = 256;

  localparam logic [1:0] F_BYTE  = 2'd0;
  localparam logic [1:0] F_TICK  = 2'd1;
  localparam logic [1:0] F_FETCH = 2'd2;

  localparam logic CFG_SLAVE = 1'b0;
  localparam logic CFG_GAP   = 1'b1;

  localparam logic [7:0] FC_RD_HOLD  = 8'd3;
  localparam logic [7:0] FC_RD_INPUT = 8'd4;
  localparam logic [7:0] FC_WR_SINGLE = 8'd6;
  localparam logic [7:0] FC_WR_MULTI = 8'd16;

  localparam logic [1:0] EXC_NONE     = 2'd0;
  localparam logic [1:0] EXC_ILL_FUNC = 2'd1;
  localparam logic [1:0] EXC_ILL_DATA = 2'd2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [15:0] RD_MAX_COUNT = 16'd125;
  localparam logic [15:0] WR_MAX_COUNT = 16'd123;

  localparam int Q_DEPTH = 2;

  typedef enum logic [2:0] {
    K_DISCARD  = 3'd0,
    K_RDHOLD   = 3'd1,
    K_RDINPUT  = 3'd2,
    K_WRSINGLE = 3'd3,
    K_WRMULTI  = 3'd4,
    K_EXCEPT   = 3'd5,
    K_WORD     = 3'd6
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic        broadcast;
    logic [7:0]  func_code;
    logic [15:0] start_address;
    logic [6:0]  register_count;
    logic [15:0] register_value;
    logic [1:0]  exc_code;
    logic        word_valid;
    logic [6:0]  word_index;
  } result_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/modbus_rtu_slave_frame_decoder_core.sv =====
// result path: a result is queued, then popped into the out_valid register
// throughput: one input word per cycle while the queue is not full; a
// two-entry queue between the decoder and the output stage absorbs output
// stalls, fetches read two byte-wide rams, and a byte waits while a valid
// fetch is still queued ahead of its ram read
// reset: synchronous active low, clears frame state and config to defaults;
// frame store contents stay undefined, no clearing pass
module modbus_rtu_slave_frame_decoder_core #(
  parameter int MAX_FRAME = mbrtu_pkg::MAX_FRAME_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_rx_byte,
  input  logic [6:0]  in_word_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic        out_broadcast,
  output logic [7:0]  out_func_code,
  output logic [15:0] out_start_address,
  output logic [6:0]  out_register_count,
  output logic [15:0] out_register_value,
  output logic [1:0]  out_exc_code,
  output logic        out_word_valid
);
  import mbrtu_pkg::*;

  localparam int HALF = (MAX_FRAME + 1) / 2;
  localparam int AW   = $clog2(HALF);

  logic          q_full, push, pop, head_valid, word_wait;
  result_t       push_entry, head;
  logic          we_odd, we_even, rd_en;
  logic [AW-1:0] waddr, rd_addr_odd, rd_addr_even;
  logic [7:0]    wdata, rd_odd, rd_even;

  mbrtu_front #(.MAX_FRAME(MAX_FRAME), .AW(AW)) u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready, .in_func, .in_rx_byte, .in_word_index,
    .q_full, .word_wait, .push, .push_entry, .we_odd, .we_even, .waddr, .wdata
  );

  mbrtu_ram #(.WIDTH(8), .DEPTH(HALF)) u_ram_odd (
    .clk, .we(we_odd), .waddr, .wdata, .re(rd_en), .raddr(rd_addr_odd), .rdata(rd_odd)
  );

  mbrtu_ram #(.WIDTH(8), .DEPTH(HALF)) u_ram_even (
    .clk, .we(we_even), .waddr, .wdata, .re(rd_en), .raddr(rd_addr_even), .rdata(rd_even)
  );

  mbrtu_fifo u_fifo (
    .clk, .rst_n, .push, .push_entry, .full(q_full), .pop, .head_valid, .head,
    .word_wait
  );

  mbrtu_back #(.AW(AW)) u_back (
    .clk, .rst_n, .head_valid, .head, .pop, .rd_en, .rd_addr_odd, .rd_addr_even,
    .rd_odd, .rd_even, .out_valid, .out_ready, .out_kind, .out_broadcast,
    .out_func_code, .out_start_address, .out_register_count,
    .out_register_value, .out_exc_code, .out_word_valid
  );

endmodule

// ===== rtl/mbrtu_ram.sv =====
module mbrtu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/mbrtu_front.sv =====
module mbrtu_front #(
  parameter int MAX_FRAME = 256,
  parameter int AW = 7
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [15:0]            cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_func,
  input  logic [7:0]             in_rx_byte,
  input  logic [6:0]             in_word_index,
  input  logic                   q_full,
  input  logic                   word_wait,
  output logic                   push,
  output mbrtu_pkg::result_t     push_entry,
  output logic                   we_odd,
  output logic                   we_even,
  output logic [AW-1:0]          waddr,
  output logic [7:0]             wdata
);
  import mbrtu_pkg::*;

  localparam int LW = $clog2(MAX_FRAME + 1);

  logic [7:0]    slave_r, slave_nxt;
  logic [15:0]   gap_r, gap_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [15:0]   sil_r, sil_nxt;
  logic [15:0]   crc_r, crc_nxt;
  logic [7:0]    hdr_r [7];
  logic [7:0]    hdr_nxt [7];
  logic [6:0]    latched_r, latched_nxt;

  logic          accept;
  logic [15:0]   sil_inc, gap_eff;
  logic          room;
  logic [15:0]   w1, w2;
  logic [7:0]    bytecnt;
  logic [9:0]    len10;
  logic          multi_ok;
  result_t       verdict;
  logic [6:0]    verdict_latch;
  logic [9:0]    fetch_top;

  // a byte waits while a queued fetch still has to read the frame store
  assign in_ready = !q_full && !(in_func == F_BYTE && word_wait);
  assign accept   = in_valid && in_ready;
  assign room     = len_r < LW'(MAX_FRAME);

  assign w1      = {hdr_r[2], hdr_r[3]};
  assign w2      = {hdr_r[4], hdr_r[5]};
  assign bytecnt = hdr_r[6];
  assign len10   = 10'(len_r);
  assign multi_ok = (len10 >= 10'd9) && (w2 >= 16'd1) && (w2 <= WR_MAX_COUNT) &&
                    ({w2, 1'b0} == {9'd0, bytecnt}) && (len10 == 10'd9 + 10'(bytecnt));

  // close decode, one verdict per frame
  always_comb begin
    verdict = '0;
    verdict.kind = K_DISCARD;
    verdict_latch = '0;
    if (len10 >= 10'd4 && crc_r == 16'd0) begin
      if (hdr_r[0] == 8'd0) begin
        if (hdr_r[1] == FC_WR_SINGLE && len10 == 10'd8) begin
          verdict.kind = K_WRSINGLE;
          verdict.broadcast = 1'b1;
          verdict.func_code = hdr_r[1];
          verdict.start_address = w1;
          verdict.register_count = 7'd1;
          verdict.register_value = w2;
        end else if (hdr_r[1] == FC_WR_MULTI && multi_ok) begin
          verdict.kind = K_WRMULTI;
          verdict.broadcast = 1'b1;
          verdict.func_code = hdr_r[1];
          verdict.start_address = w1;
          verdict.register_count = w2[6:0];
          verdict_latch = w2[6:0];
        end
      end else if (hdr_r[0] == slave_r) begin
        verdict.func_code = hdr_r[1];
        if (hdr_r[1] == FC_RD_HOLD || hdr_r[1] == FC_RD_INPUT) begin
          if (len10 != 10'd8 || w2 == 16'd0 || w2 > RD_MAX_COUNT) begin
            verdict.kind = K_EXCEPT;
            verdict.exc_code = EXC_ILL_DATA;
          end else begin
            verdict.kind = (hdr_r[1] == FC_RD_HOLD) ? K_RDHOLD : K_RDINPUT;
            verdict.start_address = w1;
            verdict.register_count = w2[6:0];
          end
        end else if (hdr_r[1] == FC_WR_SINGLE) begin
          if (len10 != 10'd8) begin
            verdict.kind = K_EXCEPT;
            verdict.exc_code = EXC_ILL_DATA;
          end else begin
            verdict.kind = K_WRSINGLE;
            verdict.start_address = w1;
            verdict.register_count = 7'd1;
            verdict.register_value = w2;
          end
        end else if (hdr_r[1] == FC_WR_MULTI) begin
          if (!multi_ok) begin
            verdict.kind = K_EXCEPT;
            verdict.exc_code = EXC_ILL_DATA;
          end else begin
            verdict.kind = K_WRMULTI;
            verdict.start_address = w1;
            verdict.register_count = w2[6:0];
            verdict_latch = w2[6:0];
          end
        end else begin
          verdict.kind = K_EXCEPT;
          verdict.exc_code = EXC_ILL_FUNC;
        end
      end
    end
  end

  assign sil_inc   = (sil_r == 16'hFFFF) ? sil_r : sil_r + 16'd1;
  assign gap_eff   = (gap_r == 16'd0) ? 16'd1 : gap_r;
  assign fetch_top = {2'b00, in_word_index, 1'b0} + 10'd8;

  always_comb begin
    slave_nxt   = slave_r;
    gap_nxt     = gap_r;
    len_nxt     = len_r;
    sil_nxt     = sil_r;
    crc_nxt     = crc_r;
    hdr_nxt     = hdr_r;
    latched_nxt = latched_r;
    push        = 1'b0;
    push_entry  = '0;
    push_entry.kind = K_DISCARD;
    we_odd      = 1'b0;
    we_even     = 1'b0;
    waddr       = len_r[AW:1];
    wdata       = in_rx_byte;

    if (cfg_we) begin
      if (cfg_index == CFG_SLAVE) begin
        slave_nxt = cfg_wdata[7:0];
      end else begin
        gap_nxt = cfg_wdata;
      end
    end

    if (accept) begin
      case (in_func)
        F_BYTE: begin
          sil_nxt = '0;
          if (room) begin
            we_odd  = len_r[0];
            we_even = !len_r[0];
            if (len_r < LW'(7)) begin
              hdr_nxt[len_r[2:0]] = in_rx_byte;
            end
            crc_nxt     = crc16_byte(crc_r, in_rx_byte);
            len_nxt     = len_r + LW'(1);
            latched_nxt = '0;
          end
        end
        F_TICK: begin
          if (len_r != '0) begin
            sil_nxt = sil_inc;
            if (sil_inc >= gap_eff) begin
              push        = 1'b1;
              push_entry  = verdict;
              latched_nxt = verdict_latch;
              len_nxt     = '0;
              sil_nxt     = '0;
              crc_nxt     = CRC_INIT;
              for (int i = 0; i < 7; i++) begin
                hdr_nxt[i] = '0;
              end
            end
          end
        end
        F_FETCH: begin
          push = 1'b1;
          push_entry.kind = K_WORD;
          push_entry.word_index = in_word_index;
          push_entry.word_valid = (in_word_index < latched_r) &&
                                  (fetch_top < 10'(MAX_FRAME));
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_r   <= 8'd1;
      gap_r     <= 16'd2;
      len_r     <= '0;
      sil_r     <= '0;
      crc_r     <= CRC_INIT;
      latched_r <= '0;
      for (int i = 0; i < 7; i++) begin
        hdr_r[i] <= '0;
      end
    end else begin
      slave_r   <= slave_nxt;
      gap_r     <= gap_nxt;
      len_r     <= len_nxt;
      sil_r     <= sil_nxt;
      crc_r     <= crc_nxt;
      latched_r <= latched_nxt;
      hdr_r     <= hdr_nxt;
    end
  end

endmodule

// ===== rtl/mbrtu_fifo.sv =====
module mbrtu_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mbrtu_pkg::result_t push_entry,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output mbrtu_pkg::result_t head,
  output logic               word_wait
);
  import mbrtu_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);

  result_t         slot_r [Q_DEPTH];
  logic [PW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [PW:0]     cnt_r, cnt_nxt;

  assign full       = cnt_r == (PW+1)'(Q_DEPTH);
  assign head_valid = cnt_r != '0;
  assign head       = slot_r[rd_r];

  // a valid fetch still queued, not counting the one read out this cycle
  always_comb begin
    word_wait = 1'b0;
    for (int i = 0; i < Q_DEPTH; i++) begin
      if ((PW+1)'(PW'(PW'(i) - rd_r)) < cnt_r && !(pop && PW'(i) == rd_r) &&
          slot_r[i].kind == K_WORD && slot_r[i].word_valid) begin
        word_wait = 1'b1;
      end
    end
  end

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(Q_DEPTH - 1)) ? '0 : wr_r + PW'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(Q_DEPTH - 1)) ? '0 : rd_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + (PW+1)'(1);
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/mbrtu_back.sv =====
module mbrtu_back #(
  parameter int AW = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  mbrtu_pkg::result_t head,
  output logic               pop,
  output logic               rd_en,
  output logic [AW-1:0]      rd_addr_odd,
  output logic [AW-1:0]      rd_addr_even,
  input  logic [7:0]         rd_odd,
  input  logic [7:0]         rd_even,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_kind,
  output logic               out_broadcast,
  output logic [7:0]         out_func_code,
  output logic [15:0]        out_start_address,
  output logic [6:0]         out_register_count,
  output logic [15:0]        out_register_value,
  output logic [1:0]         out_exc_code,
  output logic               out_word_valid
);
  import mbrtu_pkg::*;

  result_t ent_r;
  logic    valid_r;
  logic    from_ram;
  logic [7:0] a_odd, a_even;

  assign pop   = head_valid && (!valid_r || out_ready);
  assign rd_en = pop && head.kind == K_WORD && head.word_valid;
  // high byte sits at 7 + 2*index, low byte right after it
  assign a_odd  = {1'b0, head.word_index} + 8'd3;
  assign a_even = {1'b0, head.word_index} + 8'd4;
  assign rd_addr_odd  = a_odd[AW-1:0];
  assign rd_addr_even = a_even[AW-1:0];

  always_ff @(posedge clk) begin
    if (pop) begin
      ent_r <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  assign from_ram = ent_r.kind == K_WORD && ent_r.word_valid;

  assign out_valid          = valid_r;
  assign out_kind           = ent_r.kind;
  assign out_broadcast      = ent_r.broadcast;
  assign out_func_code      = ent_r.func_code;
  assign out_start_address  = ent_r.start_address;
  assign out_register_count = ent_r.register_count;
  assign out_register_value = from_ram ? {rd_odd, rd_even} : ent_r.register_value;
  assign out_exc_code       = ent_r.exc_code;
  assign out_word_valid     = ent_r.word_valid;

endmodule

// ===== rtl/mbrtu_checker.sv =====
module mbrtu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic        out_broadcast,
  input logic [7:0]  out_func_code,
  input logic [15:0] out_start_address,
  input logic [6:0]  out_register_count,
  input logic [15:0] out_register_value,
  input logic [1:0]  out_exc_code,
  input logic        out_word_valid
);
  import mbrtu_pkg::*;

  // a stalled word stays up
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("output word dropped");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_discard: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == K_DISCARD |->
      !out_broadcast && out_func_code == 8'd0 && out_start_address == 16'd0 &&
      out_register_count == 7'd0 && out_register_value == 16'd0 &&
      out_exc_code == EXC_NONE && !out_word_valid)
    else $error("discard verdict with fields set");

  a_badfetch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == K_WORD && !out_word_valid |-> out_register_value == 16'd0)
    else $error("invalid fetch returned data");

  a_exc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_exc_code != EXC_NONE |-> out_kind == K_EXCEPT)
    else $error("exception code on non-exception word");

endmodule

bind modbus_rtu_slave_frame_decoder_core mbrtu_checker u_mbrtu_checker (.*);
